>>> rtl/tdpt_pkg.sv
// Shared types and constants for the TLB demand-paging translator.
// No dependencies.
`default_nettype none
package tdpt_pkg;
	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF = 256;
	localparam int OFFSET_WIDTH_DEF = 8;
	localparam int MAX_FRAMES_DEF = 256;
	localparam int ADDR_W = 16;
	localparam int PAGE_W = 8;
	localparam int FRAME_W = 8;
	localparam int STAMP_W = 32;
	localparam int CFG_W = 9;
	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_POLICY = 1'b1;
	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU = 1'b1;

	// Result word handed from the sequencer to the output register.
	typedef struct packed {
		logic [ADDR_W-1:0] physical_address;
		logic tlb_hit;
		logic page_fault;
		logic evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
	} result_t;
endpackage
`default_nettype wire

>>> rtl/tdpt_tlb.sv
// TLB: small register file with parallel tag compare, fill and invalidate.
// Depends on tdpt_pkg.
`default_nettype none
module tdpt_tlb #(
	parameter int TLB_ENTRIES = tdpt_pkg::TLB_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [tdpt_pkg::PAGE_W-1:0] look_page,
	output logic look_hit,
	output logic [tdpt_pkg::FRAME_W-1:0] look_frame,
	input  wire logic inv_en,
	input  wire logic [tdpt_pkg::PAGE_W-1:0] inv_page,
	input  wire logic fill_en,
	input  wire logic [tdpt_pkg::PAGE_W-1:0] fill_page,
	input  wire logic [tdpt_pkg::FRAME_W-1:0] fill_frame
);
	localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	logic [tdpt_pkg::PAGE_W-1:0] tag_q [TLB_ENTRIES];
	logic [tdpt_pkg::FRAME_W-1:0] frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] valid_q;
	logic [IW-1:0] fill_q;

	// Lowest matching valid entry wins.
	always_comb begin
		look_hit = 1'b0;
		look_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == look_page) begin
				look_hit = 1'b1;
				look_frame = frame_q[i];
			end
		end
	end

	// Valid bits and fill pointer; a fill takes priority over an invalidate of the same entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q <= '0;
		end else begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (fill_en && fill_q == IW'(i))
					valid_q[i] <= 1'b1;
				else if (inv_en && tag_q[i] == inv_page)
					valid_q[i] <= 1'b0;
			end
			if (fill_en)
				fill_q <= (fill_q == IW'(TLB_ENTRIES - 1)) ? '0 : fill_q + 1'b1;
		end
	end

	// Tag and frame payload.
	always_ff @(posedge clk) begin
		if (fill_en) begin
			tag_q[fill_q] <= fill_page;
			frame_q[fill_q] <= fill_frame;
		end
	end
endmodule
`default_nettype wire

>>> rtl/tdpt_core.sv
// Sequencer with page map, frame owner and stamp memories.
// Depends on tdpt_pkg and tdpt_tlb.
`default_nettype none
module tdpt_core #(
	parameter int TLB_ENTRIES = tdpt_pkg::TLB_ENTRIES_DEF,
	parameter int OFFSET_WIDTH = tdpt_pkg::OFFSET_WIDTH_DEF,
	parameter int MAX_FRAMES = tdpt_pkg::MAX_FRAMES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tdpt_pkg::ADDR_W-1:0] addr,
	input  wire logic [tdpt_pkg::CFG_W-1:0] frames_cfg,
	input  wire logic policy,
	output logic busy,
	output logic done,
	output tdpt_pkg::result_t res
);
	localparam int PAGE_COUNT = tdpt_pkg::PAGE_COUNT_DEF;
	localparam int PW = tdpt_pkg::PAGE_W;
	localparam int FW = tdpt_pkg::FRAME_W;
	localparam int SW = tdpt_pkg::STAMP_W;
	localparam int PMASK_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOK = 4'd1;
	localparam logic [3:0] S_MAP = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_SCAN_W = 4'd4;
	localparam logic [3:0] S_OWN = 4'd5;
	localparam logic [3:0] S_OWN_W = 4'd6;
	localparam logic [3:0] S_UNMAP = 4'd7;
	localparam logic [3:0] S_LOAD = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] st_q;
	logic [PW-1:0] page_q;
	logic [OFFSET_WIDTH-1:0] off_q;
	logic [FW-1:0] frame_q;
	logic hit_q, fault_q, ev_q;
	logic [PW-1:0] evp_q;
	logic [8:0] used_q, n_q, scan_q;
	logic [FW-1:0] rr_q;
	logic [SW-1:0] clk_q, best_q;
	logic [FW-1:0] bidx_q;

	// Page map memory: frame and loaded bit per page.
	logic [FW-1:0] map_frame_m [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] map_loaded_q;
	logic [FW-1:0] map_rd_q;
	// Owner memory and stamp memory indexed by frame.
	logic [PW-1:0] owner_m [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] owner_valid_q;
	logic [PW-1:0] owner_rd_q;
	logic [SW-1:0] stamp_m [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] stamp_set_q;
	logic [SW-1:0] stamp_rd_q;
	logic stamp_rd_set_q;

	logic look_hit;
	logic [FW-1:0] look_frame;
	logic tlb_inv, tlb_fill;
	logic [FW-1:0] fill_frame;

	tdpt_tlb #(.TLB_ENTRIES(TLB_ENTRIES)) u_tlb (
		.clk(clk), .arst_n(arst_n),
		.look_page(page_q), .look_hit(look_hit), .look_frame(look_frame),
		.inv_en(tlb_inv), .inv_page(evp_q),
		.fill_en(tlb_fill), .fill_page(page_q), .fill_frame(fill_frame)
	);

	assign tlb_inv = (st_q == S_UNMAP) && ev_q;
	assign tlb_fill = (st_q == S_LOAD) && !hit_q;
	assign fill_frame = frame_q;
	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_DONE);

	// Page number: the address bits above the offset, low bits kept.
	logic [tdpt_pkg::ADDR_W-1:0] addr_sh;
	logic [PW-1:0] page_in;
	assign addr_sh = addr >> OFFSET_WIDTH;
	assign page_in = PW'(PMASK_W'(addr_sh[PW-1:0]));

	// Clamped frame count.
	logic [8:0] n_eff;
	always_comb begin
		n_eff = frames_cfg;
		if (n_eff == 9'd0) n_eff = 9'd1;
		if (n_eff > 9'(MAX_FRAMES)) n_eff = 9'(MAX_FRAMES);
	end

	logic [SW-1:0] stamp_val;
	assign stamp_val = stamp_rd_set_q ? stamp_rd_q : '0;

	// Registered memory reads, and the memory writes in S_LOAD.
	always_ff @(posedge clk) begin
		map_rd_q <= map_frame_m[page_q];
		owner_rd_q <= owner_m[frame_q];
		stamp_rd_q <= stamp_m[scan_q[FW-1:0]];
		stamp_rd_set_q <= stamp_set_q[scan_q[FW-1:0]];
		if (st_q == S_LOAD && fault_q) begin
			map_frame_m[page_q] <= frame_q;
			owner_m[frame_q] <= page_q;
		end
		if (st_q == S_LOAD)
			stamp_m[frame_q] <= clk_q;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			map_loaded_q <= '0;
			owner_valid_q <= '0;
			stamp_set_q <= '0;
			used_q <= '0;
			rr_q <= '0;
			clk_q <= '0;
			scan_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) begin
					page_q <= page_in;
					off_q <= addr[OFFSET_WIDTH-1:0];
					hit_q <= 1'b0; fault_q <= 1'b0; ev_q <= 1'b0; evp_q <= '0;
					n_q <= n_eff;
					if (clk_q != '1) clk_q <= clk_q + 1'b1;
					st_q <= S_LOOK;
				end
				S_LOOK: begin
					if (look_hit) begin
						hit_q <= 1'b1; frame_q <= look_frame; st_q <= S_LOAD;
					end else if (map_loaded_q[page_q]) begin
						st_q <= S_MAP;
					end else begin
						fault_q <= 1'b1;
						if (used_q < n_q) begin
							frame_q <= FW'(used_q); used_q <= used_q + 1'b1;
							st_q <= S_LOAD;
						end else if (policy == tdpt_pkg::POL_FIFO) begin
							frame_q <= (9'(rr_q) >= n_q) ? '0 : rr_q;
							rr_q <= ((9'(rr_q) >= n_q) || (9'(rr_q) + 9'd1 >= n_q))
								? ((9'(rr_q) >= n_q && n_q > 9'd1) ? FW'(1) : '0)
								: rr_q + 1'b1;
							st_q <= S_OWN;
						end else begin
							scan_q <= '0; bidx_q <= '0; st_q <= S_SCAN;
						end
					end
				end
				S_MAP: begin frame_q <= map_rd_q; st_q <= S_LOAD; end
				S_SCAN: begin scan_q <= scan_q + 1'b1; st_q <= S_SCAN_W; end
				// Read data for index scan_q-1 arrives; compare and step.
				S_SCAN_W: begin
					if (scan_q == 9'd1 || stamp_val < best_q) begin
						best_q <= stamp_val; bidx_q <= FW'(scan_q - 9'd1);
					end
					if (scan_q >= n_q) begin
						frame_q <= (scan_q == 9'd1 || stamp_val < best_q)
							? FW'(scan_q - 9'd1) : bidx_q;
						st_q <= S_OWN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_OWN: st_q <= S_OWN_W;
				S_OWN_W: begin
					if (owner_valid_q[frame_q]) begin
						ev_q <= 1'b1; evp_q <= owner_rd_q;
					end
					st_q <= S_UNMAP;
				end
				S_UNMAP: begin
					if (ev_q) map_loaded_q[evp_q] <= 1'b0;
					st_q <= S_LOAD;
				end
				S_LOAD: begin
					if (fault_q) begin
						map_loaded_q[page_q] <= 1'b1;
						owner_valid_q[frame_q] <= 1'b1;
					end
					stamp_set_q[frame_q] <= 1'b1;
					st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res.physical_address = tdpt_pkg::ADDR_W'({24'(frame_q), off_q} );
		res.tlb_hit = hit_q;
		res.page_fault = fault_q;
		res.evicted_valid = ev_q;
		res.evicted_page = evp_q;
	end
endmodule
`default_nettype wire

>>> rtl/tlb_demand_paging_translator.sv
// Top level of the TLB demand-paging translator: handshakes and config.
// Depends on tdpt_pkg and tdpt_core.
//
// One input word carries a virtual address; one result word returns the
// physical address with hit, fault and eviction flags. Configuration is a
// plain write port (index 0 frames_in_use, 1 replace_policy), written idle.
// From accept to result valid every item passes the look-up state; a TLB hit
// or a fault with a free frame then goes straight to the load, a page-map hit
// reads the page map first, and an eviction reads and unmaps the old owner
// before the load, an lru eviction after a scan of the stamp memory, once per
// active frame, through its single read port. One item is in work at a time;
// the next can be accepted in the cycle the result is shown at the output.
// A stalled receiver holds the result and the next item waits at the input.
// Reset clears all valid bits, the counters and the access clock at once;
// no clearing pass is needed.
`default_nettype none
module tlb_demand_paging_translator #(
	parameter int TLB_ENTRIES = tdpt_pkg::TLB_ENTRIES_DEF,
	parameter int OFFSET_WIDTH = tdpt_pkg::OFFSET_WIDTH_DEF,
	parameter int MAX_FRAMES = tdpt_pkg::MAX_FRAMES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [15:0] virt_addr,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [15:0] physical_address,
	output logic tlb_hit,
	output logic page_fault,
	output logic evicted_valid,
	output logic [7:0] evicted_page,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [8:0] cfg_data
);
	logic [8:0] frames_q;
	logic policy_q;
	logic busy, done;
	tdpt_pkg::result_t res, out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 9'd256;
			policy_q <= tdpt_pkg::POL_FIFO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdpt_pkg::CFG_FRAMES: frames_q <= cfg_data;
				tdpt_pkg::CFG_POLICY: policy_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy || (out_valid && out_stall);

	tdpt_core #(.TLB_ENTRIES(TLB_ENTRIES),
		.OFFSET_WIDTH(OFFSET_WIDTH), .MAX_FRAMES(MAX_FRAMES)) u_core (
		.clk(clk), .arst_n(arst_n), .start(in_valid && !in_stall),
		.addr(virt_addr), .frames_cfg(frames_q), .policy(policy_q),
		.busy(busy), .done(done), .res(res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) if (done) out_q <= res;

	assign physical_address = out_q.physical_address;
	assign tlb_hit = out_q.tlb_hit;
	assign page_fault = out_q.page_fault;
	assign evicted_valid = out_q.evicted_valid;
	assign evicted_page = out_q.evicted_page;
endmodule
`default_nettype wire

>>> rtl/tdpt_checker.sv
// Port-level assertions for the translator, bound to the top level.
// Depends on tlb_demand_paging_translator ports only.
`default_nettype none
module tdpt_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic tlb_hit,
	input wire logic page_fault,
	input wire logic evicted_valid,
	input wire logic [7:0] evicted_page
);
	a_hit_nofault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_fault)) else $error("hit and fault");
	a_ev_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> page_fault) else $error("evict w/o fault");
	a_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == 8'd0)
		else $error("stray evicted page");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second word taken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

bind tlb_demand_paging_translator tdpt_props u_chk (.*);
`default_nettype wire
